// ----- design/tmps_pkg.sv -----
// tmps_pkg: shared types and constants for the triangle minimum path sum block
// holds default sizes, status codes and the controller/datapath command structs
// no dependencies
`default_nettype none

package tmps_pkg;

    // default sizes
    localparam int MAX_ROWS_DEF  = 256;
    localparam int ELEM_BITS_DEF = 16;
    localparam int SUM_BITS_DEF  = 24;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK   = 2'd0;
    localparam t_status STATUS_ROWS = 2'd1;
    localparam t_status STATUS_SAT  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;     // input transaction accepted this cycle
        logic setup;    // latch sweep geometry, clear load counters
        logic issue;    // launch one sweep step
        logic result;   // capture result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_issue;   // current sweep step is the apex element
    } t_sts;

endpackage

`default_nettype wire

// ----- design/tmps_ctrl.sv -----
// tmps_ctrl: control state machine for the triangle minimum path sum block
// sequences load, sweep and result hand-off; uses tmps_pkg
`default_nettype none

module tmps_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire tmps_pkg::t_sts i_sts,
    output tmps_pkg::t_cmd     o_cmd
);
    import tmps_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd.load   = (r_state == S_LOAD) && i_in_valid;
        o_cmd.setup  = (r_state == S_SETUP);
        o_cmd.issue  = (r_state == S_SWEEP);
        o_cmd.result = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (o_cmd.load && i_in_last) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (i_sts.last_issue) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (o_cmd.result) begin
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (o_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/tmps_datapath.sv -----
// tmps_datapath: element store, best-sum row and sweep arithmetic
// two-step sweep pipeline (read, then min/add/clamp/write); uses tmps_pkg
`default_nettype none

module tmps_datapath #(
    parameter int MAX_ROWS  = tmps_pkg::MAX_ROWS_DEF,
    parameter int ELEM_BITS = tmps_pkg::ELEM_BITS_DEF,
    parameter int SUM_BITS  = tmps_pkg::SUM_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tmps_pkg::t_cmd              i_cmd,
    output tmps_pkg::t_sts                   o_sts,
    input  wire logic signed [ELEM_BITS-1:0] i_value,
    output logic signed [SUM_BITS-1:0]       o_min_sum,
    output tmps_pkg::t_status                o_status
);
    import tmps_pkg::*;

    localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
    localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int WAW = $clog2(STORE_DEPTH + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int BIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int XW  = ((ELEM_BITS > SUM_BITS) ? ELEM_BITS : SUM_BITS) + 1;

    localparam logic signed [XW-1:0] SUM_HI =
        {{(XW - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
    localparam logic signed [XW-1:0] SUM_LO =
        {{(XW - SUM_BITS + 1){1'b1}}, {(SUM_BITS - 1){1'b0}}};

    // memories
    logic signed [ELEM_BITS-1:0] r_elem_mem [STORE_DEPTH];
    logic signed [SUM_BITS-1:0]  r_best_mem [MAX_ROWS];
    logic signed [ELEM_BITS-1:0] r_elem_rd;
    logic signed [SUM_BITS-1:0]  r_best_rd;

    // load counters
    logic [RCW-1:0] r_row_cnt;
    logic [RCW-1:0] r_col_cnt;
    logic [WAW-1:0] r_waddr;
    logic           r_ovf;

    // sweep geometry
    logic [BIW-1:0] r_si;
    logic [BIW-1:0] r_sj;
    logic [SAW-1:0] r_sbase;
    logic           r_init;
    logic           r_partial;
    logic [BIW-1:0] r_plen;
    logic           r_ovf_lat;
    logic           r_sat;

    // second sweep step
    logic           r_p1_valid;
    logic [BIW-1:0] r_p1_j;
    logic           r_p1_init;
    logic           r_p1_zero;
    logic signed [SUM_BITS-1:0] r_head;
    logic signed [SUM_BITS-1:0] r_prev;

    logic signed [SUM_BITS-1:0] r_out_sum;
    t_status                    r_out_status;

    // setup geometry
    logic           w_partial;
    logic [RCW-1:0] w_row_m1;
    logic [BIW-1:0] w_bottom;
    logic [WAW-1:0] w_base;
    logic           w_row_full;

    // sweep addressing
    logic [SAW-1:0] w_elem_ra;
    logic [BIW-1:0] w_best_ra;
    logic           w_row_end;

    // step arithmetic
    logic signed [SUM_BITS-1:0] w_a;
    logic signed [SUM_BITS-1:0] w_min;
    logic signed [XW-1:0]       w_elem_x;
    logic signed [XW-1:0]       w_min_x;
    logic signed [XW-1:0]       w_sum;
    logic                       w_hi;
    logic                       w_lo;
    logic signed [SUM_BITS-1:0] n_best;

    assign w_partial  = (r_col_cnt != '0);
    assign w_row_m1   = r_row_cnt - RCW'(1);
    assign w_bottom   = w_partial ? r_row_cnt[BIW-1:0] : w_row_m1[BIW-1:0];
    assign w_base     = r_waddr - (w_partial ? WAW'(r_col_cnt) : WAW'(r_row_cnt));
    assign w_row_full = (r_row_cnt >= RCW'(MAX_ROWS));

    assign w_elem_ra = r_sbase + SAW'(r_sj);
    assign w_best_ra = r_sj + BIW'(1);
    assign w_row_end = (r_sj == r_si);

    assign o_sts.last_issue = w_row_end && (r_si == '0);

    always_comb begin
        w_a      = (r_p1_j == '0) ? r_head : r_prev;
        w_min    = (w_a < r_best_rd) ? w_a : r_best_rd;
        w_elem_x = r_p1_zero ? '0
                 : $signed({{(XW - ELEM_BITS){r_elem_rd[ELEM_BITS-1]}}, r_elem_rd});
        w_min_x  = $signed({{(XW - SUM_BITS){w_min[SUM_BITS-1]}}, w_min});
        w_sum    = w_elem_x + (r_p1_init ? '0 : w_min_x);
        w_hi     = (w_sum > SUM_HI);
        w_lo     = (w_sum < SUM_LO);
        if (w_hi) begin
            n_best = SUM_HI[SUM_BITS-1:0];
        end else if (w_lo) begin
            n_best = SUM_LO[SUM_BITS-1:0];
        end else begin
            n_best = w_sum[SUM_BITS-1:0];
        end
    end

    // element store: written while loading, read while sweeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_row_full) begin
            r_elem_mem[r_waddr[SAW-1:0]] <= i_value;
        end
        if (i_cmd.issue) begin
            r_elem_rd <= r_elem_mem[w_elem_ra];
        end
    end

    // best-sum row, write-first for the one-entry-row turnaround
    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            r_best_mem[r_p1_j] <= n_best;
        end
        if (i_cmd.issue) begin
            if (r_p1_valid && (r_p1_j == w_best_ra)) begin
                r_best_rd <= n_best;
            end else begin
                r_best_rd <= r_best_mem[w_best_ra];
            end
        end
    end

    // load counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_waddr   <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.setup) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_waddr   <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_row_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_waddr <= r_waddr + WAW'(1);
                if (r_col_cnt == r_row_cnt) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= r_row_cnt + RCW'(1);
                end else begin
                    r_col_cnt <= r_col_cnt + RCW'(1);
                end
            end
        end
    end

    // sweep counters, bottom row first then upward
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_si      <= w_bottom;
            r_sj      <= '0;
            r_sbase   <= w_base[SAW-1:0];
            r_init    <= 1'b1;
            r_partial <= w_partial;
            r_plen    <= r_col_cnt[BIW-1:0];
            r_ovf_lat <= r_ovf;
        end else if (i_cmd.issue) begin
            if (w_row_end) begin
                r_si    <= r_si - BIW'(1);
                r_sj    <= '0;
                r_sbase <= r_sbase - SAW'(r_si);
                r_init  <= 1'b0;
            end else begin
                r_sj <= r_sj + BIW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_p1_j    <= r_sj;
            r_p1_init <= r_init;
            r_p1_zero <= r_init && r_partial && (r_sj >= r_plen);
        end
    end

    // step results
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_sat <= 1'b0;
        end else if (r_p1_valid) begin
            r_sat <= r_sat | w_hi | w_lo;
        end
        if (r_p1_valid) begin
            r_prev <= r_best_rd;
            if (r_p1_j == '0) begin
                r_head <= n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_out_sum <= r_head;
            if (r_ovf_lat) begin
                r_out_status <= STATUS_ROWS;
            end else if (r_sat) begin
                r_out_status <= STATUS_SAT;
            end else begin
                r_out_status <= STATUS_OK;
            end
        end
    end

    assign o_min_sum = r_out_sum;
    assign o_status  = r_out_status;

endmodule

`default_nettype wire

// ----- design/triangle_min_path_sum.sv -----
// triangle_min_path_sum: top level, minimum apex-to-bottom path sum of a number triangle
// joins tmps_ctrl and tmps_datapath; uses tmps_pkg
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | into      | i_in_valid / o_in_stall    | i_value, i_last
//  out     | out of    | o_out_valid / i_out_stall  | o_min_sum, o_status
//
// elements load at one per cycle while the input is not stalled; a triangle whose bottom row
// index is b then passes setup, (b+1)(b+2)/2 sweep steps (one per element through the
// best-row memory port), a drain state and a finish state into the output register
// synchronous active-low reset clears the load counters and control; both memories start unknown
// the input stalls from the last element until the result sits in the output register
// a held result does not block loading of the next triangle
`default_nettype none

module triangle_min_path_sum #(
    parameter int MAX_ROWS  = tmps_pkg::MAX_ROWS_DEF,
    parameter int ELEM_BITS = tmps_pkg::ELEM_BITS_DEF,
    parameter int SUM_BITS  = tmps_pkg::SUM_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input transactions
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [ELEM_BITS-1:0] i_value,
    input  wire logic                        i_last,
    // result transactions
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [SUM_BITS-1:0]       o_min_sum,
    output tmps_pkg::t_status                o_status
);
    import tmps_pkg::*;

    t_cmd w_cmd;   // controller commands
    t_sts w_sts;   // datapath status

    // state machine: load, setup, sweep, drain, hand off result
    tmps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // element store, best row, min/add/clamp step and output register
    tmps_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .ELEM_BITS (ELEM_BITS),
        .SUM_BITS  (SUM_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_value   (i_value),
        .o_min_sum (o_min_sum),
        .o_status  (o_status)
    );

`ifndef SYNTH
    // sweeping and loading never overlap
    a_no_load_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> (o_in_stall && !w_cmd.load))
        else $error("sweep step issued while input is open");

    // a new result never overwrites one still held by a stalled consumer
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.result |-> !(o_out_valid && i_out_stall))
        else $error("result captured over a pending transaction");

    // result capture is followed by a valid output
    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.result |=> o_out_valid)
        else $error("captured result not presented");

    // status is one of the defined codes whenever a result is presented
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK || o_status == STATUS_ROWS ||
                         o_status == STATUS_SAT))
        else $error("undefined status code on output");
`endif

endmodule

`default_nettype wire

// ----- tb/tmps_path_checker.sv -----
`timescale 1ns / 100ps
// tmps_path_checker: watches both channels of triangle_min_path_sum and checks each result
// keeps its own copy of the triangle and predicts the minimum path sum; uses tmps_pkg
module tmps_path_checker #(
    parameter int MAX_ROWS  = tmps_pkg::MAX_ROWS_DEF,
    parameter int ELEM_BITS = tmps_pkg::ELEM_BITS_DEF,
    parameter int SUM_BITS  = tmps_pkg::SUM_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [ELEM_BITS-1:0] i_value,
    input  logic                        i_last,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [SUM_BITS-1:0]  i_min_sum,
    input  tmps_pkg::t_status           i_status,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_row_flags,
    output int                          o_fail_count
);
    localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
    localparam longint SUM_HI = (64'sd1 << (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] min_sum;
        tmps_pkg::t_status          status;
    } path_result_t;

    logic signed [ELEM_BITS-1:0] triangle_mem [STORE_DEPTH];
    longint                      best_row [MAX_ROWS];
    int unsigned                 row_cnt;
    int unsigned                 col_cnt;
    int unsigned                 wr_addr;
    logic                        rows_dropped;
    path_result_t                expected_paths [$];
    int                          pending;
    int                          checked;
    int                          row_flags;
    int                          fail_count;

    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_row_flags  = row_flags;
    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic longint clamp_sum(input longint x, inout logic sat);
        if (x > SUM_HI) begin
            sat = 1'b1;
            return SUM_HI;
        end
        if (x < SUM_LO) begin
            sat = 1'b1;
            return SUM_LO;
        end
        return x;
    endfunction

    function automatic longint elem_at(input int unsigned r, input int unsigned c);
        int unsigned a;
        a = r * (r + 1) / 2 + c;
        if (a >= STORE_DEPTH) begin
            return 0;
        end
        return longint'(triangle_mem[a]);
    endfunction

    // bottom-up sweep over the stored triangle, missing bottom entries count as zero
    function automatic path_result_t predict_min_path();
        int unsigned  n_rows;
        int unsigned  partial;
        int           bottom;
        int           r;
        int           j;
        longint       elem;
        longint       low;
        logic         sat;
        path_result_t res;
        n_rows  = row_cnt;
        partial = 0;
        sat     = 1'b0;
        if (col_cnt != 0 && row_cnt < MAX_ROWS) begin
            partial = col_cnt;
            n_rows  = row_cnt + 1;
        end
        bottom = int'(n_rows) - 1;
        for (j = 0; j <= bottom; j++) begin
            elem        = (partial != 0 && j >= int'(partial)) ? 0 : elem_at(bottom, j);
            best_row[j] = clamp_sum(elem, sat);
        end
        for (r = bottom - 1; r >= 0; r--) begin
            for (j = 0; j <= r; j++) begin
                low         = (best_row[j] < best_row[j+1]) ? best_row[j] : best_row[j+1];
                best_row[j] = clamp_sum(elem_at(r, j) + low, sat);
            end
        end
        res.min_sum = SUM_BITS'(best_row[0]);
        res.status  = rows_dropped ? tmps_pkg::STATUS_ROWS :
                      (sat ? tmps_pkg::STATUS_SAT : tmps_pkg::STATUS_OK);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        path_result_t want;
        if (!i_rst_n) begin
            row_cnt      = 0;
            col_cnt      = 0;
            wr_addr      = 0;
            rows_dropped = 1'b0;
            expected_paths.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_paths.size() == 0) begin
                    report_mismatch($sformatf("result sum %0d status %0d with nothing expected",
                                              i_min_sum, i_status));
                end else begin
                    want = expected_paths.pop_front();
                    checked++;
                    if (want.status == tmps_pkg::STATUS_ROWS) begin
                        row_flags++;
                    end
                    if (i_min_sum !== want.min_sum) begin
                        report_mismatch($sformatf("min_sum %0d, expected %0d",
                                                  i_min_sum, want.min_sum));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (row_cnt >= MAX_ROWS) begin
                    rows_dropped = 1'b1;
                end else begin
                    if (wr_addr < STORE_DEPTH) begin
                        triangle_mem[wr_addr] = i_value;
                    end
                    wr_addr++;
                    col_cnt++;
                    if (col_cnt > row_cnt) begin
                        col_cnt = 0;
                        row_cnt++;
                    end
                end
                if (i_last) begin
                    expected_paths.push_back(predict_min_path());
                    row_cnt      = 0;
                    col_cnt      = 0;
                    wr_addr      = 0;
                    rows_dropped = 1'b0;
                end
            end
        end
        pending = expected_paths.size();
    end

endmodule

// ----- tb/tb_triangle_min_path_sum.sv -----
`timescale 1ns / 100ps
// tb_triangle_min_path_sum: stimulus and verdict for triangle_min_path_sum
// drives triangles in, stalls results at random, tmps_path_checker does the checking
module tb_triangle_min_path_sum;

    localparam int MAX_ROWS   = tmps_pkg::MAX_ROWS_DEF;
    localparam int ELEM_BITS  = tmps_pkg::ELEM_BITS_DEF;
    localparam int SUM_BITS   = tmps_pkg::SUM_BITS_DEF;
    localparam logic signed [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
    localparam logic signed [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
    localparam int RANDOM_ITEMS = 700;

    // how the element values of one triangle are picked
    typedef enum int {
        VAL_RANDOM,
        VAL_ALL_MAX,
        VAL_ALL_MIN,
        VAL_EXTREMES,
        VAL_SMALL,
        VAL_ZERO
    } value_mode_t;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    logic signed [ELEM_BITS-1:0] i_value     = '0;
    logic                        i_last      = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [SUM_BITS-1:0]  o_min_sum;
    tmps_pkg::t_status           o_status;

    // checker status
    int pending;
    int checked;
    int row_flags;
    int fail_count;

    // stimulus bookkeeping
    int   triangles_sent = 0;
    int   elems_sent     = 0;
    logic gaps_on        = 1'b1;
    logic stalls_on      = 1'b1;

    always #1 i_clk = ~i_clk;

    triangle_min_path_sum #(
        .MAX_ROWS  (MAX_ROWS),
        .ELEM_BITS (ELEM_BITS),
        .SUM_BITS  (SUM_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_min_sum   (o_min_sum),
        .o_status    (o_status)
    );

    // predicts and compares every result transaction
    tmps_path_checker #(
        .MAX_ROWS  (MAX_ROWS),
        .ELEM_BITS (ELEM_BITS),
        .SUM_BITS  (SUM_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_min_sum    (o_min_sum),
        .i_status     (o_status),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_row_flags  (row_flags),
        .o_fail_count (fail_count)
    );

    // hard stop well past the slowest legal run with the longest gaps and stalls
    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int rows_to_elems(input int rows);
        return rows * (rows + 1) / 2;
    endfunction

    // idle or stall length: mostly short, now and then long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return pick_len();
    endfunction

    function automatic logic signed [ELEM_BITS-1:0] pick_value(input value_mode_t mode);
        case (mode)
            VAL_ALL_MAX: begin
                return ELEM_MAX;
            end
            VAL_ALL_MIN: begin
                return ELEM_MIN;
            end
            VAL_EXTREMES: begin
                case ($urandom_range(0, 4))
                    0: return ELEM_MAX;
                    1: return ELEM_MIN;
                    2: return '0;
                    3: return '1;
                    default: return 1;
                endcase
            end
            VAL_SMALL: begin
                return ELEM_BITS'(int'($urandom_range(0, 15)) - 8);
            end
            VAL_ZERO: begin
                return '0;
            end
            default: begin
                return ELEM_BITS'($urandom);
            end
        endcase
    endfunction

    // random values dominate, the patterned modes hit the corners
    function automatic value_mode_t pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return VAL_RANDOM;
        end
        return value_mode_t'(r - 4);
    endfunction

    // one input transaction: optional idle gap, then hold until not stalled
    task automatic send_elem(input logic signed [ELEM_BITS-1:0] v, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last     <= lst;
        // stall is settled by the falling edge; the next rising edge takes the item
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        elems_sent++;
    endtask

    // n_elems that does not fill the bottom row leaves a partial bottom row
    task automatic send_triangle(input int n_elems, input value_mode_t mode);
        for (int k = 0; k < n_elems; k++) begin
            send_elem(pick_value(mode), k == n_elems - 1);
        end
        triangles_sent++;
    endtask

    // sender goes quiet until every predicted result has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // result side stall: random bursts, sometimes switched off for a stretch
    initial begin : result_stall
        int len;
        @(posedge i_clk);
        forever begin
            if (stalls_on && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                len = pick_len();
            end else begin
                i_out_stall <= 1'b0;
                len = $urandom_range(1, 6);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int random_elems;
        int rows;
        int n_elems;
        int r;
        random_elems = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: apex-only triangles at the value extremes, small full
        // triangles, and partial bottom rows whose missing entries count as zero
        send_triangle(1, VAL_ALL_MAX);
        send_triangle(1, VAL_ALL_MIN);
        send_triangle(1, VAL_ZERO);
        send_triangle(2, VAL_RANDOM);
        send_triangle(3, VAL_EXTREMES);
        send_triangle(4, VAL_SMALL);
        send_triangle(5, VAL_RANDOM);
        send_triangle(6, VAL_EXTREMES);
        wait_drained();

        // random triangles, mostly small, about a quarter with a partial bottom row
        while (random_elems < RANDOM_ITEMS) begin
            if (triangles_sent % 16 == 0) begin
                wait_drained();
            end
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                rows = $urandom_range(1, 5);
            end else if (r < 90) begin
                rows = $urandom_range(6, 12);
            end else begin
                rows = $urandom_range(13, 24);
            end
            n_elems = rows_to_elems(rows);
            if ($urandom_range(0, 3) == 0) begin
                n_elems = rows_to_elems(rows - 1) + $urandom_range(1, rows);
            end
            send_triangle(n_elems, pick_mode());
            random_elems += n_elems;
        end

        // drain, then leave room for any stray result
        stalls_on = 1'b1;
        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("run covered %0d triangles from %0d elements, partial bottom rows included",
                 triangles_sent, elems_sent);
        $display("%0d results checked, %0d of them flagged for too many rows",
                 checked, row_flags);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- triangle_min_path_sum.f -----
design/tmps_pkg.sv
design/tmps_ctrl.sv
design/tmps_datapath.sv
design/triangle_min_path_sum.sv
tb/tmps_path_checker.sv
tb/tb_triangle_min_path_sum.sv
